[design/vfbd_pkg.sv]
// Shared types, register map, status codes and helpers for the voice frame
// bundle deframer. Depends on nothing; every other design file imports it.

package vfbd_pkg;

	// Defaults for the top-level parameters.
	localparam int HDR_DEPTH_DEF = 64;
	localparam int LEN_BITS_DEF  = 16;

	// Depth of the queue between the front and the back; a power of two.
	localparam int QUEUE_DEPTH = 2;

	// Configuration port.
	localparam int PADDR_W = 5;

	// Output tdata width: 37 bits of fields padded to whole bytes.
	localparam int TDATA_W = 40;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_EIGHTH = 3'd0;
	localparam logic [2:0] REG_CUSTOM = 3'd1;
	localparam logic [2:0] REG_HALF   = 3'd2;
	localparam logic [2:0] REG_FULL   = 3'd3;
	localparam logic [2:0] REG_LIMIT  = 3'd4;

	// Register reset values.
	localparam logic [5:0] RESET_LEN_EIGHTH = 6'd2;
	localparam logic [5:0] RESET_LEN_CUSTOM = 6'd5;
	localparam logic [5:0] RESET_LEN_HALF   = 6'd10;
	localparam logic [5:0] RESET_LEN_FULL   = 6'd22;
	localparam logic [7:0] RESET_LIMIT      = 8'd255;

	// Packet status codes.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_SHORT     = 3'd1;
	localparam logic [2:0] STAT_BAD_COUNT = 3'd2;
	localparam logic [2:0] STAT_HDR_TRUNC = 3'd3;
	localparam logic [2:0] STAT_FRM_TRUNC = 3'd4;

	// A packet shorter than this many bytes is reported as short.
	localparam logic [2:0] PKT_LEN_MIN = 3'd4;

	typedef struct packed {
		logic [3:0][5:0] rate_len;
		logic [7:0]      frame_limit;
	} cfg_t;

	// One input byte as classified by the front.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       short_pkt;
		logic       first;
	} qitem_t;

	// One result transaction.
	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_number;
		logic [1:0]  rate_code;
		logic        frame_end;
		logic        status_valid;
		logic [2:0]  status;
		logic [15:0] bytes_used;
	} res_t;

	typedef enum logic [2:0] {
		B_COUNT,
		B_HEADER,
		B_SETTLE,
		B_FETCH,
		B_PAYLOAD,
		B_DONE
	} bst_t;

	// Rate code of a frame within its header byte, most significant pair first.
	function automatic logic [1:0] rate_of(input logic [7:0] hdr, input logic [1:0] pos);
		logic [1:0] r;
		case (pos)
			2'd0: r = hdr[7:6];
			2'd1: r = hdr[5:4];
			2'd2: r = hdr[3:2];
			default: r = hdr[1:0];
		endcase
		return r;
	endfunction

endpackage

[design/voice_frame_bundle_deframer.sv]
// Voice frame bundle deframer, top level: front, queue, sequencer and registers.
// A byte goes through the queue to the sequencer, which registers its result in the
// output register. Throughput: one payload byte a cycle while the receiver keeps up;
// no byte is taken in the settle state after the header and for each skipped
// zero-length frame, nor in the fetch state at each new header byte (every fourth
// frame). The sequencer takes no byte while a result waits unread, or while a
// packet that ended in the frame walk settles its status; the input stalls once the
// queue is full. Reset: arst_n clears all control state and restores register defaults;
// the header store is not cleared, as every entry is written before it is read.

module voice_frame_bundle_deframer #(
	parameter int HEADER_DEPTH = vfbd_pkg::HDR_DEPTH_DEF,
	parameter int LENGTH_BITS  = vfbd_pkg::LEN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input byte stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] packet_byte
	input  logic                         s_tlast,   // packet_end
	// Result stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] payload_byte, [15:8] frame_number, [17:16] rate_code,
	// [20:18] status, [36:21] bytes_used, [39:37] zero
	output logic [vfbd_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tlast,   // frame_end
	output logic [1:0]                   m_tuser,   // [0] payload_valid, [1] status_valid
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vfbd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import vfbd_pkg::*;

	// The front takes each input transaction, notes whether it opens a packet
	// and whether the packet is still under the short-packet threshold, and
	// drops it into the queue. The sequencer behind the queue walks the
	// packet: it stores header bytes, steps through the frames (fetching a
	// header byte from the store for each group of four frames after the
	// first) and builds one result transaction per payload byte or packet end.
	// No byte is taken while the output register holds an unread result.

	cfg_t   cfg;
	qitem_t item;
	qitem_t head;
	res_t   res;
	logic   push;
	logic   q_full;
	logic   q_valid;
	logic   pop;
	logic   out_valid;

	vfbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vfbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.s_tready (s_tready),
		.push     (push),
		.item     (item)
	);

	vfbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (item),
		.pop     (pop),
		.full    (q_full),
		.valid   (q_valid),
		.head    (head)
	);

	vfbd_back #(
		.HEADER_DEPTH (HEADER_DEPTH),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.m_ready   (m_tready),
		.out_valid (out_valid),
		.out       (res)
	);

	// Pack the result fields onto the stream, lowest field first.
	assign m_tvalid = out_valid;
	assign m_tdata  = {3'b000, res.bytes_used, res.status, res.rate_code,
		res.frame_number, res.payload_byte};
	assign m_tlast  = res.frame_end;
	assign m_tuser  = {res.status_valid, res.payload_valid};

endmodule

[design/vfbd_cfg.sv]
// Configuration register file behind the APB-style port.
// Depends on vfbd_pkg for the register map, reset values and cfg_t.

module vfbd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vfbd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output vfbd_pkg::cfg_t               cfg
);
	import vfbd_pkg::*;

	logic [PADDR_W-3:0] idx;
	logic               wr;
	logic [3:0][5:0]    rl_q;
	logic [7:0]         lim_q;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q[0] <= RESET_LEN_EIGHTH;
			rl_q[1] <= RESET_LEN_CUSTOM;
			rl_q[2] <= RESET_LEN_HALF;
			rl_q[3] <= RESET_LEN_FULL;
			lim_q   <= RESET_LIMIT;
		end else if (wr) begin
			case (idx)
				REG_EIGHTH: rl_q[0] <= pwdata[5:0];
				REG_CUSTOM: rl_q[1] <= pwdata[5:0];
				REG_HALF:   rl_q[2] <= pwdata[5:0];
				REG_FULL:   rl_q[3] <= pwdata[5:0];
				REG_LIMIT:  lim_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_EIGHTH: prdata = {26'd0, rl_q[0]};
			REG_CUSTOM: prdata = {26'd0, rl_q[1]};
			REG_HALF:   prdata = {26'd0, rl_q[2]};
			REG_FULL:   prdata = {26'd0, rl_q[3]};
			REG_LIMIT:  prdata = {24'd0, lim_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.rate_len    = rl_q;
	assign cfg.frame_limit = lim_q;

endmodule

[design/vfbd_front.sv]
// Input side: accepts bytes and tags each with its place in the packet.
// Depends on vfbd_pkg for qitem_t and the short-packet threshold.

module vfbd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic [7:0]       s_tdata,
	input  logic             s_tlast,
	input  logic             q_full,
	output logic             s_tready,
	output logic             push,
	output vfbd_pkg::qitem_t item
);
	import vfbd_pkg::*;

	// Bytes of the current packet seen so far, saturating at the threshold.
	logic [2:0] pkt_len_q;
	logic [2:0] len_next;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;
	assign len_next = (pkt_len_q == PKT_LEN_MIN) ? pkt_len_q : pkt_len_q + 3'd1;

	assign item.data      = s_tdata;
	assign item.last      = s_tlast;
	assign item.short_pkt = (len_next < PKT_LEN_MIN);
	assign item.first     = (pkt_len_q == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_len_q <= 3'd0;
		end else if (push) begin
			pkt_len_q <= s_tlast ? 3'd0 : len_next;
		end
	end

endmodule

[design/vfbd_queue.sv]
// Short FIFO of classified bytes between the front and the back.
// Depends on vfbd_pkg for qitem_t and QUEUE_DEPTH.

module vfbd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vfbd_pkg::qitem_t item_in,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output vfbd_pkg::qitem_t head
);
	import vfbd_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	qitem_t           mem_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

[design/vfbd_back.sv]
// Packet sequencer: header store, frame walk, status and the output register.
// Depends on vfbd_pkg for cfg_t, qitem_t, res_t, bst_t and rate_of.

module vfbd_back #(
	parameter int HEADER_DEPTH = vfbd_pkg::HDR_DEPTH_DEF,
	parameter int LENGTH_BITS  = vfbd_pkg::LEN_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vfbd_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  vfbd_pkg::qitem_t head,
	output logic             pop,
	input  logic             m_ready,
	output logic             out_valid,
	output vfbd_pkg::res_t   out
);
	import vfbd_pkg::*;

	localparam int         AW     = (HEADER_DEPTH > 1) ? $clog2(HEADER_DEPTH) : 1;
	localparam logic [7:0] DEPTH8 = 8'(HEADER_DEPTH);

	typedef struct packed {
		bst_t       st;
		logic [7:0] cur;
		logic [5:0] left;
	} adv_t;

	// Step on to frame g: finished, a new header byte to fetch, or one to examine.
	function automatic adv_t move_to(input logic [8:0] g, input logic [7:0] total);
		adv_t a;
		a.st   = B_DONE;
		a.cur  = g[7:0];
		a.left = 6'd0;
		if (g < {1'b0, total}) begin
			a.st = (g[1:0] == 2'd0) ? B_FETCH : B_SETTLE;
		end
		return a;
	endfunction

	// Examine frame f with its header byte: start its payload or skip it.
	function automatic adv_t examine(input logic [7:0] f, input logic [7:0] hdr,
			input logic [3:0][5:0] rl, input logic [7:0] total);
		adv_t       a;
		logic [5:0] len;
		len = rl[rate_of(hdr, f[1:0])];
		if (len != 6'd0) begin
			a.st   = B_PAYLOAD;
			a.cur  = f;
			a.left = len;
		end else begin
			a = move_to({1'b0, f} + 9'd1, total);
		end
		return a;
	endfunction

	function automatic logic [15:0] low16(input logic [LENGTH_BITS-1:0] v);
		logic [LENGTH_BITS+15:0] w;
		w = {16'd0, v};
		return w[15:0];
	endfunction

	bst_t                   st_q, st_d, it_st;
	logic [7:0]             total_q, total_d, it_total;
	logic [6:0]             nhdr_q, nhdr_d, it_nhdr, nhdr_calc;
	logic [7:0]             cur_q, cur_d, it_cur, cur_inc;
	logic [5:0]             left_q, left_d, it_left;
	logic [2:0]             err_q, err_d, it_err;
	logic [LENGTH_BITS-1:0] seen_q, seen_d, it_seen, seen_inc;
	logic                   pend_q, pend_d;
	logic [8:0]             cnt_plus3;

	logic [7:0]             hdr_q, hdr_d, hdr_eff, rd_q, rd_eff;
	logic                   rd_zero_q, rd_en, mem_we;
	logic [5:0]             rd_slot;
	logic [7:0]             hdr_mem [HEADER_DEPTH];

	res_t                   pres_q, pres_d, res_item, res_fin, out_q;
	logic                   pshort_q, pshort_d, out_valid_q;
	logic [2:0]             item_status, fin_status;

	logic                   can_out, take, defer, resolves, fin, adv_go, emit_item;
	adv_t                   pay_adv, pay_move, set_adv;

	assign can_out  = !out_valid_q || m_ready;
	assign take     = q_valid && can_out && (st_q inside {B_COUNT, B_HEADER, B_PAYLOAD, B_DONE});
	assign pop      = take;

	assign seen_inc  = (&seen_q) ? seen_q : seen_q + LENGTH_BITS'(1);
	assign cur_inc   = cur_q + 8'd1;
	assign cnt_plus3 = {1'b0, head.data} + 9'd3;
	assign nhdr_calc = cnt_plus3[8:2];

	assign rd_eff  = rd_zero_q ? 8'd0 : rd_q;
	assign hdr_eff = (st_q == B_FETCH) ? rd_eff : hdr_q;

	// Frame walk after a frame ends, and the step taken while settling.
	always_comb begin
		pay_move = move_to({1'b0, cur_q} + 9'd1, total_q);
		if (pay_move.st == B_SETTLE) begin
			pay_adv = examine(pay_move.cur, hdr_q, cfg.rate_len, total_q);
		end else begin
			pay_adv = pay_move;
		end
		set_adv = examine(cur_q, hdr_eff, cfg.rate_len, total_q);
	end

	// Effect of the byte taken from the queue.
	always_comb begin
		it_st    = st_q;
		it_total = total_q;
		it_nhdr  = nhdr_q;
		it_cur   = cur_q;
		it_left  = left_q;
		it_err   = err_q;
		it_seen  = seen_q;
		if (take) begin
			case (st_q)
				B_COUNT: begin
					it_total = head.data;
					if (cfg.frame_limit == 8'd0 || head.data > cfg.frame_limit) begin
						it_err = STAT_BAD_COUNT;
						it_st  = B_DONE;
					end else begin
						it_seen = seen_inc;
						it_cur  = 8'd0;
						it_nhdr = nhdr_calc;
						it_st   = (head.data == 8'd0) ? B_DONE : B_HEADER;
					end
				end
				B_HEADER: begin
					it_seen = seen_inc;
					if (cur_inc >= {1'b0, nhdr_q}) begin
						it_cur = 8'd0;
						it_st  = B_SETTLE;
					end else begin
						it_cur = cur_inc;
					end
				end
				B_PAYLOAD: begin
					it_seen = seen_inc;
					if (left_q == 6'd1) begin
						it_st   = pay_adv.st;
						it_cur  = pay_adv.cur;
						it_left = pay_adv.left;
					end else begin
						it_left = left_q - 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign defer    = take && head.last && (it_st inside {B_SETTLE, B_FETCH});
	assign resolves = (set_adv.st inside {B_PAYLOAD, B_DONE});
	assign adv_go   = (st_q inside {B_SETTLE, B_FETCH}) && !(pend_q && resolves);
	assign fin      = (st_q inside {B_SETTLE, B_FETCH}) && pend_q && resolves && can_out;

	// Next state.
	always_comb begin
		st_d    = st_q;
		total_d = total_q;
		nhdr_d  = nhdr_q;
		cur_d   = cur_q;
		left_d  = left_q;
		err_d   = err_q;
		seen_d  = seen_q;
		pend_d  = pend_q;
		if (take) begin
			st_d    = it_st;
			total_d = it_total;
			nhdr_d  = it_nhdr;
			cur_d   = it_cur;
			left_d  = it_left;
			err_d   = it_err;
			seen_d  = it_seen;
			pend_d  = defer;
		end else if (adv_go) begin
			st_d   = set_adv.st;
			cur_d  = set_adv.cur;
			left_d = set_adv.left;
		end
		if ((take && head.last && !defer) || fin) begin
			st_d    = B_COUNT;
			total_d = 8'd0;
			cur_d   = 8'd0;
			left_d  = 6'd0;
			err_d   = STAT_OK;
			seen_d  = '0;
			pend_d  = 1'b0;
		end
	end

	// Outputs of the sequencer.
	always_comb begin
		if (head.short_pkt) begin
			item_status = STAT_SHORT;
		end else if (it_err != STAT_OK) begin
			item_status = it_err;
		end else begin
			case (it_st)
				B_HEADER:  item_status = STAT_HDR_TRUNC;
				B_PAYLOAD: item_status = STAT_FRM_TRUNC;
				default:   item_status = STAT_OK;
			endcase
		end

		res_item = '0;
		if (take && st_q == B_PAYLOAD) begin
			res_item.payload_valid = 1'b1;
			res_item.payload_byte  = head.data;
			res_item.frame_number  = cur_q;
			res_item.rate_code     = rate_of(hdr_q, cur_q[1:0]);
			res_item.frame_end     = (left_q == 6'd1);
		end
		if (take && head.last && !defer) begin
			res_item.status_valid = 1'b1;
			res_item.status       = item_status;
			res_item.bytes_used   = (item_status == STAT_OK) ? low16(it_seen) : 16'd0;
		end

		if (pshort_q) begin
			fin_status = STAT_SHORT;
		end else if (set_adv.st == B_PAYLOAD) begin
			fin_status = STAT_FRM_TRUNC;
		end else begin
			fin_status = STAT_OK;
		end
		res_fin              = pres_q;
		res_fin.status_valid = 1'b1;
		res_fin.status       = fin_status;
		res_fin.bytes_used   = (fin_status == STAT_OK) ? low16(seen_q) : 16'd0;

		emit_item = take && (st_q == B_PAYLOAD || head.last) && !defer;
		pres_d    = defer ? res_item : pres_q;
		pshort_d  = defer ? head.short_pkt : pshort_q;

		mem_we = take && (st_q == B_HEADER) && (cur_q < DEPTH8);
		rd_en  = (st_d == B_FETCH);
		rd_slot = cur_d[7:2];

		hdr_d = hdr_q;
		if (take && st_q == B_HEADER && cur_q == 8'd0) begin
			hdr_d = head.data;
		end else if (st_q == B_FETCH) begin
			hdr_d = rd_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_COUNT;
			total_q     <= 8'd0;
			nhdr_q      <= 7'd0;
			cur_q       <= 8'd0;
			left_q      <= 6'd0;
			err_q       <= STAT_OK;
			seen_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			total_q <= total_d;
			nhdr_q  <= nhdr_d;
			cur_q   <= cur_d;
			left_q  <= left_d;
			err_q   <= err_d;
			seen_q  <= seen_d;
			pend_q  <= pend_d;
			if (emit_item || fin) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and the header store.
	always_ff @(posedge clk) begin
		hdr_q    <= hdr_d;
		pres_q   <= pres_d;
		pshort_q <= pshort_d;
		if (emit_item) begin
			out_q <= res_item;
		end else if (fin) begin
			out_q <= res_fin;
		end
		if (mem_we) begin
			hdr_mem[cur_q[AW-1:0]] <= head.data;
		end
		if (rd_en) begin
			rd_q      <= hdr_mem[rd_slot[AW-1:0]];
			rd_zero_q <= ({2'b00, rd_slot} >= DEPTH8);
		end
	end

	assign out_valid = out_valid_q;
	assign out       = out_q;

	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (st_q == B_SETTLE || st_q == B_FETCH))
		else $error("pending status held outside the frame walk");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_PAYLOAD) |-> (left_q != 6'd0))
		else $error("payload state with no bytes left in the frame");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_PAYLOAD) |-> (cur_q < total_q))
		else $error("payload frame index beyond the frame count");

	a_count_align: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (head.first == (st_q == B_COUNT)))
		else $error("count byte taken out of step with the packet start");

	a_fetch_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_FETCH) |-> (cur_q[1:0] == 2'b00))
		else $error("header fetch away from a header byte boundary");

endmodule

[verif/voice_frame_bundle_deframer_tb.sv]
// Self-checking testbench for the voice frame bundle deframer: a directed part,
// register sweeps, a back-pressure test and randomised packets against a local model.
// Depends on vfbd_pkg and voice_frame_bundle_deframer from the design folder.

module voice_frame_bundle_deframer_tb;
	import vfbd_pkg::*;

	// Rough number of input bytes the whole run should push through.
	localparam int BYTE_BUDGET = 1750;
	// Cycles allowed after the last expected result before registers change.
	localparam int QUIET_CYCLES = 16;

	typedef logic [7:0] byte_q_t[$];

	// Where the model stands within the current packet.
	typedef enum logic [1:0] {
		AWAIT_COUNT,
		IN_HEADER,
		IN_PAYLOAD,
		PKT_DONE
	} pkt_phase_t;

	// One result transaction as the block should present it.
	typedef struct {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_number;
		logic [1:0]  rate_code;
		logic        frame_end;
		logic        status_valid;
		logic [2:0]  status;
		logic [15:0] bytes_used;
	} deframed_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tlast;
	logic [1:0]           m_tuser;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// Model copy of the registers.
	logic [5:0] rate_len [4];
	logic [7:0] frame_cap;

	// Model copy of the per-packet state.
	pkt_phase_t phase;
	logic [7:0] nframes;
	logic [7:0] hdr_mem [HDR_DEPTH_DEF];
	logic [15:0] used_bytes;
	int         frame_idx;
	logic [5:0] left;
	logic [2:0] err;
	int         pkt_len;

	// Results still owed by the block, oldest first.
	deframed_t pending[$];

	// Knobs shared by the stimulus and the receiving side.
	bit gaps_on = 1'b1;
	int rx_hold = 0;

	int mismatches = 0;
	int bytes_sent = 0;
	int packets_sent = 0;
	int settings_used = 0;
	int payload_seen = 0;
	int status_seen [5] = '{default: 0};

	voice_frame_bundle_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A hard stop, far beyond the slowest correct run.
	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------

	// Every discrepancy is printed on one line and counted.
	task automatic log_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Model of the deframer
	// ------------------------------------------------------------------

	// Rate pair of one frame within its header byte, most significant pair first.
	function automatic logic [1:0] pair_at(input logic [7:0] hdr, input int pos);
		logic [7:0] s;
		s = hdr >> (6 - 2 * pos);
		return s[1:0];
	endfunction

	function automatic logic [1:0] frame_rate(input int f);
		return pair_at(hdr_mem[f / 4], f % 4);
	endfunction

	function automatic int header_len(input logic [7:0] n);
		return (int'(n) + 3) / 4;
	endfunction

	task automatic clear_packet();
		phase = AWAIT_COUNT;
		nframes = '0;
		used_bytes = '0;
		frame_idx = 0;
		left = '0;
		err = STAT_OK;
		pkt_len = 0;
	endtask

	task automatic reset_model();
		rate_len[0] = RESET_LEN_EIGHTH;
		rate_len[1] = RESET_LEN_CUSTOM;
		rate_len[2] = RESET_LEN_HALF;
		rate_len[3] = RESET_LEN_FULL;
		frame_cap = RESET_LIMIT;
		foreach (hdr_mem[i]) hdr_mem[i] = '0;
		clear_packet();
	endtask

	// Step over frames whose length is zero; they take no bytes and are never
	// marked as ended. Once the frames run out the rest of the packet is ignored.
	task automatic next_frame();
		while (frame_idx < int'(nframes)) begin
			if (rate_len[frame_rate(frame_idx)] != 0) begin
				left = rate_len[frame_rate(frame_idx)];
				phase = IN_PAYLOAD;
				return;
			end
			frame_idx++;
		end
		left = '0;
		phase = PKT_DONE;
	endtask

	// Work out what one accepted input byte should produce.
	task automatic deframe_byte(input logic [7:0] b, input logic last);
		deframed_t r;
		r = '{default: '0};
		if (pkt_len < int'(PKT_LEN_MIN)) pkt_len++;
		case (phase)
			AWAIT_COUNT: begin
				nframes = b;
				if (frame_cap == 0 || b > frame_cap) begin
					err = STAT_BAD_COUNT;
					phase = PKT_DONE;
				end else begin
					if (used_bytes != 16'hFFFF) used_bytes++;
					frame_idx = 0;
					if (header_len(nframes) == 0) next_frame();
					else phase = IN_HEADER;
				end
			end
			IN_HEADER: begin
				if (frame_idx < HDR_DEPTH_DEF) hdr_mem[frame_idx] = b;
				frame_idx++;
				if (used_bytes != 16'hFFFF) used_bytes++;
				if (frame_idx >= header_len(nframes)) begin
					frame_idx = 0;
					next_frame();
				end
			end
			IN_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.frame_number = frame_idx[7:0];
				r.rate_code = frame_rate(frame_idx);
				if (used_bytes != 16'hFFFF) used_bytes++;
				if (left > 0) left--;
				if (left == 0) begin
					r.frame_end = 1'b1;
					frame_idx++;
					next_frame();
				end
			end
			default: ;
		endcase
		if (last) begin
			r.status_valid = 1'b1;
			if (pkt_len < int'(PKT_LEN_MIN)) r.status = STAT_SHORT;
			else if (err != STAT_OK) r.status = err;
			else if (phase == IN_HEADER) r.status = STAT_HDR_TRUNC;
			else if (phase == IN_PAYLOAD) r.status = STAT_FRM_TRUNC;
			else r.status = STAT_OK;
			r.bytes_used = (r.status == STAT_OK) ? used_bytes : 16'd0;
			clear_packet();
		end
		if (r.payload_valid || r.status_valid) pending.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Each result transaction is compared with the oldest one still owed.
	task automatic compare_result();
		deframed_t want;
		if (pending.size() == 0) begin
			log_mismatch("result with nothing outstanding", m_tdata, '0);
			return;
		end
		want = pending.pop_front();
		if (m_tuser[0] !== want.payload_valid)
			log_mismatch("payload_valid", m_tuser[0], want.payload_valid);
		if (m_tdata[7:0] !== want.payload_byte)
			log_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
		if (m_tdata[15:8] !== want.frame_number)
			log_mismatch("frame_number", m_tdata[15:8], want.frame_number);
		if (m_tdata[17:16] !== want.rate_code)
			log_mismatch("rate_code", m_tdata[17:16], want.rate_code);
		if (m_tlast !== want.frame_end)
			log_mismatch("frame_end", m_tlast, want.frame_end);
		if (m_tuser[1] !== want.status_valid)
			log_mismatch("status_valid", m_tuser[1], want.status_valid);
		if (m_tdata[20:18] !== want.status)
			log_mismatch("status", m_tdata[20:18], want.status);
		if (m_tdata[36:21] !== want.bytes_used)
			log_mismatch("bytes_used", m_tdata[36:21], want.bytes_used);
		if (m_tdata[39:37] !== 3'b000)
			log_mismatch("tdata padding", m_tdata[39:37], '0);
		if (want.payload_valid) payload_seen++;
		if (want.status_valid && want.status < 5) status_seen[want.status]++;
	endtask

	// Values are sampled at the edge, before the block's registers update, so they
	// are the ones the block presented when the transaction took place.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) compare_result();
	end

	// With gaps on, the receiver stalls for a random number of cycles before each result.
	// A test may ask for a long hold-off through rx_hold; it is counted here,
	// after the next transaction, so the block has already started to fill.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = gaps_on ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte after a random gap and hold it until the block takes it.
	// tvalid is only lowered when a gap is drawn, so a back-to-back byte keeps
	// it high with a single assignment in that time step.
	task automatic push_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		deframe_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i]) push_byte(seq[i], i == seq.size() - 1);
		packets_sent++;
	endtask

	// Build a well-formed packet for the current register values: count byte,
	// header, payload and optional trailing bytes. A non-negative fixed_rate
	// gives every frame that rate; a cut above zero truncates the packet.
	task automatic send_packet(input int count, input int cut, input int trail,
			input int fixed_rate);
		byte_q_t pkt;
		logic [1:0] r;
		pkt = {};
		pkt.push_back(count[7:0]);
		for (int i = 0; i < (count + 3) / 4; i++)
			pkt.push_back(fixed_rate < 0 ? 8'($urandom) : {4{fixed_rate[1:0]}});
		for (int f = 0; f < count; f++) begin
			r = pair_at(pkt[1 + f / 4], f % 4);
			repeat (int'(rate_len[r])) pkt.push_back(8'($urandom));
		end
		repeat (trail) pkt.push_back(8'($urandom));
		if (cut > 0) begin
			while (pkt.size() > cut) void'(pkt.pop_back());
		end
		send_seq(pkt);
	endtask

	// Stop offering bytes, wait for every owed result, then let the block idle.
	task automatic drain(input int tail);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register.
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (idx == REG_LIMIT) frame_cap = value;
		else rate_len[idx[1:0]] = value[5:0];
		want = (idx == REG_LIMIT) ? 32'(value) : 32'(value[5:0]);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want) log_mismatch("register read-back", 40'(prdata), 40'(want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only with the block idle and nothing outstanding.
	task automatic set_config(input int eighth, input int custom, input int half,
			input int full, input int cap);
		drain(QUIET_CYCLES);
		write_reg(REG_EIGHTH, 8'(eighth));
		write_reg(REG_CUSTOM, 8'(custom));
		write_reg(REG_HALF, 8'(half));
		write_reg(REG_FULL, 8'(full));
		write_reg(REG_LIMIT, 8'(cap));
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-written packets: one with the reset lengths, then every status,
	// extreme byte values, zero-length frames, trailing bytes and a frame that
	// ends on the final byte of the packet.
	task automatic test_directed();
		byte_q_t q;
		q = {8'h01, 8'h00, 8'h3C, 8'hC3};
		send_seq(q);
		set_config(1, 0, 2, 1, 16);
		q = {8'h00};
		send_seq(q);
		q = {8'hFF, 8'hFF, 8'h00, 8'h55};
		send_seq(q);
		q = {8'h10, 8'hA5, 8'h5A, 8'hC3};
		send_seq(q);
		q = {8'h00, 8'h12, 8'h34, 8'h56};
		send_seq(q);
		// Five frames; the second and the fifth have no bytes.
		q = {8'h05, 8'h1B, 8'h7F, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
		send_seq(q);
		q = {8'h02, 8'h80, 8'hFE, 8'h7E};
		send_seq(q);
		q = {8'h01, 8'h80, 8'h11, 8'h22};
		send_seq(q);
	endtask

	// Sweeps the registers through their extremes.
	task automatic test_registers();
		// Every frame empty: the packet is count, header and any trailing bytes.
		set_config(0, 0, 0, 0, 255);
		send_packet(255, 0, 2, -1);
		send_packet(3, 0, 0, -1);
		send_packet(0, 0, 3, -1);
		// Longest frames and the smallest non-zero limit.
		set_config(63, 63, 63, 63, 1);
		send_packet(1, 0, 1, -1);
		send_packet(2, 5, 0, -1);
		// The most frames a packet can hold, one byte each, so frame numbers
		// run all the way up.
		set_config(1, 63, 63, 63, 255);
		send_packet(255, 0, 0, 0);
		// A zero limit turns every packet away.
		set_config(3, 0, 5, 1, 0);
		send_packet(0, 0, 3, -1);
		send_packet(6, 10, 0, -1);
		set_config($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(1, 255));
		repeat (4) send_packet($urandom_range(0, 3), 0, $urandom_range(0, 2), -1);
	endtask

	// The receiver holds off while the sender streams a long packet, so the
	// block fills and has to refuse input; then the sender waits for the block
	// to empty before the next packet.
	task automatic test_backpressure();
		set_config(20, 3, 7, 1, 255);
		gaps_on = 1'b0;
		rx_hold = 150;
		send_packet(4, 0, 0, 0);
		drain(0);
		rx_hold = 60;
		send_packet(8, 0, 1, -1);
		drain(0);
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed packets with random content, the rest truncated,
	// short or plain noise. Registers and idling change between epochs.
	task automatic test_random();
		byte_q_t q;
		int kind;
		int count;
		while (bytes_sent < BYTE_BUDGET) begin
			set_config($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9),
				$urandom_range(0, 9),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 255);
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (30) begin
				if (bytes_sent >= BYTE_BUDGET) break;
				kind = $urandom_range(0, 99);
				count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
				if (kind < 65) begin
					send_packet(count, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, -1);
				end else if (kind < 80) begin
					send_packet(count, $urandom_range(1, 40), 0, -1);
				end else if (kind < 90) begin
					send_packet(count, $urandom_range(1, 3), 0, -1);
				end else begin
					q = {};
					repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
					send_seq(q);
				end
				if ($urandom_range(0, 15) == 0) drain(0);
			end
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------

	initial begin
		int waited;
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_registers();
		test_backpressure();
		test_random();

		// Wait for the last results, with a bound, then a short tail in case
		// the block produces anything it should not.
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		foreach (pending[i]) log_mismatch("result never delivered", '0, 40'(pending[i].status));

		$display("Sent %0d bytes in %0d packets over %0d register settings; %0d payload bytes checked.",
			bytes_sent, packets_sent, settings_used, payload_seen);
		$display("Packet outcomes: ok %0d, short %0d, bad count %0d, header cut %0d, frame cut %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
design/vfbd_pkg.sv
design/vfbd_cfg.sv
design/vfbd_front.sv
design/vfbd_queue.sv
design/vfbd_back.sv
design/voice_frame_bundle_deframer.sv
verif/voice_frame_bundle_deframer_tb.sv
